// File: design/scp_pkg.sv
package scp_pkg;

	// defaults for the top-level parameters
	localparam int AFB_DEF  = 16;
	localparam int RFB_DEF  = 14;

	// internal fixed point: 28 fraction bits
	localparam int WFB      = 28;
	localparam int ANGLE_W  = 24;
	localparam int VALUE_W  = 16;

	// biased angle word; holds the scaled angle at the coarsest angle format
	localparam int XW        = 47;
	localparam int RED_STEPS = 16;	// restoring reduction steps, 2pi<<15 .. 2pi<<0
	localparam int RW        = 31;	// reduced angle, below 2pi
	localparam int YW        = 29;	// folded angle, at most pi/2
	localparam int SW        = 30;	// y*y
	localparam int T5W       = 22;
	localparam int T3W       = 26;
	localparam int T1W       = 29;
	localparam int OW        = 32;	// rounding / saturation word

	localparam logic [XW-1:0] HALF_PI_X  = XW'(64'd421657428);
	localparam logic [XW-1:0] TWO_PI_X   = XW'(64'd1686629712);
	// 2pi<<15 exceeds any negative scaled angle, so the sum stays positive
	localparam logic [XW-1:0] MOD_BIAS   = TWO_PI_X << (RED_STEPS - 1);

	localparam logic [RW-1:0] Q_HALF_PI  = RW'(64'd421657428);
	localparam logic [RW-1:0] Q_PI       = RW'(64'd843314856);
	localparam logic [RW-1:0] Q_3HALF_PI = RW'(64'd1264972284);
	localparam logic [RW-1:0] Q_TWO_PI   = RW'(64'd1686629712);

	localparam logic [T5W-1:0] Q_C5  = T5W'(32'd2236962);
	localparam logic [15:0]    Q_C7  = 16'd53261;
	localparam logic [T3W-1:0] Q_C3  = T3W'(32'd44739243);
	localparam logic [T1W-1:0] Q_ONE = T1W'(32'd268435456);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW    = 2;

	typedef struct packed {
		logic          neg;
		logic [YW-1:0] y;
	} scp_fold_t;

	typedef struct packed {
		logic full;
		logic empty;
	} scp_fifo_stat_t;

endpackage

// File: design/scp_front.sv
module scp_front #(
	parameter int ANGLE_FRAC_BITS = scp_pkg::AFB_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_op,
	input  logic [scp_pkg::ANGLE_W-1:0] in_angle,
	output logic                        out_valid,
	input  logic                        out_ready,
	output scp_pkg::scp_fold_t          out_word
);
	import scp_pkg::*;

	localparam int SH = WFB - ANGLE_FRAC_BITS;

	logic          en;
	logic [XW-1:0] ang_ext;
	logic [XW-1:0] biased;
	logic [XW-1:0] red_s [0:RED_STEPS];
	logic          vld_s [0:RED_STEPS];
	logic [RW-1:0] r;
	scp_fold_t     fold_d;
	scp_fold_t     fold_s;
	logic          fold_vld_s;

	assign en        = !fold_vld_s || out_ready;
	assign in_ready  = en;
	assign out_valid = fold_vld_s;
	assign out_word  = fold_s;

	assign ang_ext = {{(XW - ANGLE_W){in_angle[ANGLE_W-1]}}, in_angle};
	assign biased  = (ang_ext << SH) + (in_op ? HALF_PI_X : '0) + MOD_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s[0] <= biased;
		end
	end

	// one conditional subtract of 2pi<<k per stage
	for (genvar i = 0; i < RED_STEPS; i++) begin : g_red
		localparam logic [XW-1:0] STEP = TWO_PI_X << (RED_STEPS - 1 - i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				red_s[i+1] <= (red_s[i] >= STEP) ? red_s[i] - STEP : red_s[i];
			end
		end
	end

	assign r = red_s[RED_STEPS][RW-1:0];

	always_comb begin
		if (r <= Q_HALF_PI) begin
			fold_d.y   = YW'(r);
			fold_d.neg = 1'b0;
		end else if (r <= Q_PI) begin
			fold_d.y   = YW'(Q_PI - r);
			fold_d.neg = 1'b0;
		end else if (r <= Q_3HALF_PI) begin
			fold_d.y   = YW'(r - Q_PI);
			fold_d.neg = 1'b1;
		end else begin
			fold_d.y   = YW'(Q_TWO_PI - r);
			fold_d.neg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_vld_s <= 1'b0;
		end else if (en) begin
			fold_vld_s <= vld_s[RED_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s <= fold_d;
		end
	end

endmodule

// File: design/scp_fifo.sv
module scp_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  scp_pkg::scp_fold_t     push_word,
	input  logic                   pop,
	output scp_pkg::scp_fold_t     pop_word,
	output scp_pkg::scp_fifo_stat_t stat
);
	import scp_pkg::*;

	scp_fold_t          mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_PW-1:0] wr_q;
	logic [FIFO_PW-1:0] rd_q;
	logic [FIFO_PW:0]   cnt_q;

	assign stat.full  = (cnt_q == (FIFO_PW+1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_word   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_PW+1)'(push) - (FIFO_PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

endmodule

// File: design/scp_back.sv
module scp_back #(
	parameter int RESULT_FRAC_BITS = scp_pkg::RFB_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  scp_pkg::scp_fold_t          in_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [scp_pkg::VALUE_W-1:0] out_value
);
	import scp_pkg::*;

	localparam logic [OW-1:0] RND = OW'(1) << (WFB - 1 - RESULT_FRAC_BITS);
	localparam logic [OW-1:0] SAT = OW'(1) << RESULT_FRAC_BITS;

	logic           en;
	logic [6:1]     vld_s;
	logic [YW-1:0]  y_s1, y_s2, y_s3, y_s4;
	logic [5:1]     neg_s;
	logic [SW-1:0]  s_s1, s_s2, s_s3;
	logic [T5W-1:0] t5_s2;
	logic [T3W-1:0] t3_s3;
	logic [T1W-1:0] t1_s4;
	logic [YW-1:0]  p_s5;
	logic [VALUE_W-1:0] value_s6;

	logic [2*YW-1:0]      yy;
	logic [SW+16-1:0]     m7;
	logic [SW+T5W-1:0]    m5;
	logic [SW+T3W-1:0]    m3;
	logic [YW+T1W-1:0]    m1;
	logic [OW-1:0]        q_r, q_c, v;

	assign en        = !vld_s[6] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s[6];
	assign out_value = value_s6;

	assign yy  = {{YW{1'b0}}, in_word.y} * {{YW{1'b0}}, in_word.y};
	assign m7  = {16'd0, s_s1} * {{SW{1'b0}}, Q_C7};
	assign m5  = {{T5W{1'b0}}, s_s2} * {{SW{1'b0}}, t5_s2};
	assign m3  = {{T3W{1'b0}}, s_s3} * {{SW{1'b0}}, t3_s3};
	assign m1  = {{T1W{1'b0}}, y_s4} * {{YW{1'b0}}, t1_s4};

	// round half up, clamp to one, then apply quadrant sign
	assign q_r = (OW'(p_s5) + RND) >> (WFB - RESULT_FRAC_BITS);
	assign q_c = (q_r > SAT) ? SAT : q_r;
	assign v   = neg_s[5] ? (~q_c + 1'b1) : q_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[5:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s    <= {neg_s[4:1], in_word.neg};
			y_s1     <= in_word.y;
			s_s1     <= SW'(yy >> WFB);
			y_s2     <= y_s1;
			s_s2     <= s_s1;
			t5_s2    <= Q_C5 - T5W'(m7 >> WFB);
			y_s3     <= y_s2;
			s_s3     <= s_s2;
			t3_s3    <= Q_C3 - T3W'(m5 >> WFB);
			y_s4     <= y_s3;
			t1_s4    <= Q_ONE - T1W'(m3 >> WFB);
			p_s5     <= YW'(m1 >> WFB);
			value_s6 <= v[VALUE_W-1:0];
		end
	end

endmodule

// File: design/sine_cosine_polynomial_core.sv
// Sine / cosine core: each word carries a signed angle in radians (tdata, fixed point with
// ANGLE_FRAC_BITS fraction bits) and a selector (tuser, 0 sine, 1 cosine). Cosine adds pi/2,
// the angle is reduced modulo 2pi and folded into the first quadrant, and the quadrant sets the
// sign. The result is the 7th-order Taylor polynomial evaluated in Horner form with 28 internal
// fraction bits, rounded half up to RESULT_FRAC_BITS fraction bits and clamped to +/-1. One word
// is taken per clock while tready is high. The pipeline has one input register, sixteen restoring
// subtract stages for the 2pi reduction, a fold stage, the hand-off queue, and six polynomial
// stages (a multiply in each of the first five) ending in the output register. A four-word queue sits between the
// reduction front and the polynomial back; input tready drops only when the fold stage holds a
// word and the queue is full, and then the whole front stalls.
module sine_cosine_polynomial_core #(
	parameter int ANGLE_FRAC_BITS  = scp_pkg::AFB_DEF,
	parameter int RESULT_FRAC_BITS = scp_pkg::RFB_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,	// [23:0] angle
	input  logic [0:0]  s_axis_tuser,	// [0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata	// [15:0] value
);
	import scp_pkg::*;

	localparam int LIM = 1 << RESULT_FRAC_BITS;

	logic           f_valid;
	logic           f_ready;
	scp_fold_t      f_word;
	scp_fold_t      q_word;
	scp_fifo_stat_t q_stat;
	logic           push;
	logic           pop;
	logic           b_ready;

	// front: scale, bias, reduce, fold
	scp_front #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser[0]),
		.in_angle  (s_axis_tdata),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_word  (f_word)
	);

	assign f_ready = !q_stat.full;
	assign push    = f_valid && f_ready;
	assign pop     = !q_stat.empty && b_ready;

	scp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (f_word),
		.pop       (pop),
		.pop_word  (q_word),
		.stat      (q_stat)
	);

	// back: Horner polynomial, rounding, sign
	scp_back #(
		.RESULT_FRAC_BITS(RESULT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!q_stat.empty),
		.in_ready  (b_ready),
		.in_word   (q_word),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full)) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty)) else $error("queue read while empty");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty)) else $error("queue status inconsistent");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (RESULT_FRAC_BITS > 14) ||
			((int'($signed(m_axis_tdata)) <= LIM) && (int'($signed(m_axis_tdata)) >= -LIM)))
		else $error("result outside +/-1");

endmodule

// File: dv/sine_cosine_polynomial_core_tb.sv
`timescale 1ns / 1ps

module sine_cosine_polynomial_core_tb;
	import scp_pkg::*;

	localparam int AFB = AFB_DEF;
	localparam int RFB = RFB_DEF;
	// angle selector values carried on tuser
	localparam logic SEL_SINE = 1'b0;
	localparam logic SEL_COSINE = 1'b1;
	localparam int N_RANDOM = 1550;
	localparam int DRAIN_CYCLES = 60;

	// Q28 constants for the predictor
	localparam longint P_HALF_PI = 64'd421657428;
	localparam longint P_PI = 2 * P_HALF_PI;
	localparam longint P_3HALF_PI = 3 * P_HALF_PI;
	localparam longint P_TWO_PI = 4 * P_HALF_PI;
	localparam longint P_ONE = 64'd1 << 28;
	localparam longint P_C3 = 64'd44739243;
	localparam longint P_C5 = 64'd2236962;
	localparam longint P_C7 = 64'd53261;

	typedef struct {
		logic        sel;
		logic [23:0] angle;
	} angle_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;	// [23:0] angle
	logic [0:0]  s_axis_tuser;	// [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;	// [15:0] value
	logic        s_axis_tready_q;

	angle_word_t     pending_angles[$];
	logic [15:0]     expected_values[$];
	int              errors;
	bit              hold_sender;	// set by the stimulus to drain the pipe
	bit              no_idle;		// long stretch without any idling

	sine_cosine_polynomial_core #(
		.ANGLE_FRAC_BITS (AFB),
		.RESULT_FRAC_BITS(RFB)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// 7th-order Taylor series on the folded angle, all products truncated
	function automatic longint taylor7(longint y);
		longint s, t;
		s = (y * y) >>> 28;
		t = P_C5 - ((s * P_C7) >>> 28);
		t = P_C3 - ((s * t) >>> 28);
		t = P_ONE - ((s * t) >>> 28);
		return (y * t) >>> 28;
	endfunction

	function automatic logic [15:0] predict_trig(logic sel, logic [23:0] angle);
		longint x, r, y, q, v;
		bit neg;
		x = longint'(signed'(angle)) * (64'd1 << (28 - AFB));
		if (sel == SEL_COSINE)
			x += P_HALF_PI;
		r = x % P_TWO_PI;
		if (r < 0)
			r += P_TWO_PI;
		if (r <= P_HALF_PI) begin
			y = r; neg = 0;
		end else if (r <= P_PI) begin
			y = P_PI - r; neg = 0;
		end else if (r <= P_3HALF_PI) begin
			y = r - P_PI; neg = 1;
		end else begin
			y = P_TWO_PI - r; neg = 1;
		end
		q = (taylor7(y) + (64'd1 << (27 - RFB))) >>> (28 - RFB);
		if (q > (64'd1 << RFB))
			q = 64'd1 << RFB;
		v = neg ? -q : q;
		return v[15:0];
	endfunction

	task automatic push_angle(logic sel, logic [23:0] angle);
		angle_word_t w;
		w.sel = sel;
		w.angle = angle;
		pending_angles.push_back(w);
	endtask

	// driver: new word presented at the falling edge once the old one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready_q) begin
			if (pending_angles.size() != 0 && !hold_sender &&
				(no_idle || $urandom_range(99) >= 24)) begin
				angle_word_t w;
				w = pending_angles.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= w.angle;
				s_axis_tuser <= w.sel;
				expected_values.push_back(predict_trig(w.sel, w.angle));
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= no_idle || ($urandom_range(99) >= 24);
	end

	// acceptance of the presented word, sampled at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s_axis_tready_q <= 1'b0;
		else
			s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				logic [15:0] exp_v;
				exp_v = expected_values.pop_front();
				if (m_axis_tdata !== exp_v) begin
					$display("%0t: value mismatch, expected %h, actual %h",
						$time, exp_v, m_axis_tdata);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [23:0] a;
		logic        sel;
		errors = 0;
		hold_sender = 0;
		no_idle = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, both functions, quadrant edges, multiples of 2pi
		for (int s = 0; s < 2; s++) begin
			sel = s[0] ? SEL_COSINE : SEL_SINE;
			push_angle(sel, 24'h000000);
			push_angle(sel, 24'h7FFFFF);
			push_angle(sel, 24'h800000);
			push_angle(sel, 24'hFFFFFF);
			push_angle(sel, 24'(P_HALF_PI >>> (28 - AFB)));
			push_angle(sel, 24'(P_PI >>> (28 - AFB)));
			push_angle(sel, 24'(P_3HALF_PI >>> (28 - AFB)));
			push_angle(sel, 24'(P_TWO_PI >>> (28 - AFB)));
			push_angle(sel, 24'((P_TWO_PI >>> (28 - AFB)) + 1));
			push_angle(sel, 24'(-(P_TWO_PI >>> (28 - AFB))));
			push_angle(sel, 24'(-(P_HALF_PI >>> (28 - AFB))));
		end
		wait (pending_angles.size() == 0);
		// pause the sender until every prediction is met
		hold_sender = 1;
		wait (expected_values.size() == 0);
		hold_sender = 0;

		for (int i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(3))
				0: a = $urandom();
				1: a = 24'($urandom_range(0, 2 * 411774)) - 24'd411774;	// within +/- 2pi
				2: a = {$urandom_range(1) ? 4'hF : 4'h0, 20'($urandom())};
				default: a = 24'($urandom_range(0, 6)) * 24'd102944 + 24'($urandom_range(0, 4)) - 24'd2;
			endcase
			push_angle(1'($urandom()), a);
			if (i == 500)
				no_idle = 1;
			if (i == 900)
				no_idle = 0;
			if (i == 500 || i == 900)
				wait (pending_angles.size() < 50);
		end
		wait (pending_angles.size() == 0);
		wait (expected_values.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_values.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
